@@ src/qau_pkg.sv @@
// ----------------------------------------------------------------------------
// Quaternion arithmetic unit package
// Shared widths, operation codes and the side-band record that travels with
// each transaction through the root and divider pipelines.
// ----------------------------------------------------------------------------
package qau_pkg;

   localparam int FRAC_BITS = 16;
   localparam int COMP_W    = 32;

   // Exact product of two components and the sum of four such products.
   localparam int PROD_W    = 2 * COMP_W;
   localparam int HSUM_W    = PROD_W + 2;
   // Squared norm is a sum of four nonnegative squares.
   localparam int NSQ_W     = PROD_W + 1;
   // Integer square root of the squared norm.
   localparam int ROOT_W    = COMP_W + 1;
   // Dividend of the inverse, which is the widest of the two divisions.
   localparam int DVD_W     = COMP_W + 2 * FRAC_BITS;
   // Quotient bound: the inverse is at most 2^(2*FRAC_BITS).
   localparam int QUO_W     = 2 * FRAC_BITS + 1;
   // Width of a shifted divisor during the division.
   localparam int TRY_W     = NSQ_W + QUO_W;

   typedef enum logic [2:0] {
      OP_ADD  = 3'd0,
      OP_SUB  = 3'd1,
      OP_MUL  = 3'd2,
      OP_SCL  = 3'd3,
      OP_CONJ = 3'd4,
      OP_INV  = 3'd5,
      OP_NORM = 3'd6,
      OP_LEN  = 3'd7
   } op_type;

   typedef struct packed {
      op_type                   op;
      logic                     nz;    // squared norm is nonzero
      logic [3:0][COMP_W-1:0]   res;   // finished result of the direct operations
      logic                     ov;
      logic [3:0][COMP_W-1:0]   mag;   // magnitudes of the first operand
      logic [3:0]               neg;   // sign of each divided component
      logic [ROOT_W-1:0]        len;   // filled in at the end of the root pipeline
   } side_type;

endpackage

@@ src/qau_req_if.sv @@
// ----------------------------------------------------------------------------
// Quaternion request channel
// Valid/ready channel carrying an operation code, two quaternions and a scalar.
// ----------------------------------------------------------------------------
interface qau_req_if;
   logic                                valid;
   logic                                ready;
   logic [2:0]                          operation;
   logic signed [qau_pkg::COMP_W-1:0]   a_w;
   logic signed [qau_pkg::COMP_W-1:0]   a_x;
   logic signed [qau_pkg::COMP_W-1:0]   a_y;
   logic signed [qau_pkg::COMP_W-1:0]   a_z;
   logic signed [qau_pkg::COMP_W-1:0]   b_w;
   logic signed [qau_pkg::COMP_W-1:0]   b_x;
   logic signed [qau_pkg::COMP_W-1:0]   b_y;
   logic signed [qau_pkg::COMP_W-1:0]   b_z;
   logic signed [qau_pkg::COMP_W-1:0]   scalar;

   modport source (output valid, operation, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
                   scalar, input ready);
   modport sink   (input valid, operation, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
                   scalar, output ready);
endinterface

@@ src/qau_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Quaternion response channel
// Valid/ready channel carrying one result quaternion and its overflow flag.
// ----------------------------------------------------------------------------
interface qau_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [qau_pkg::COMP_W-1:0]   r_w;
   logic signed [qau_pkg::COMP_W-1:0]   r_x;
   logic signed [qau_pkg::COMP_W-1:0]   r_y;
   logic signed [qau_pkg::COMP_W-1:0]   r_z;
   logic                                overflow;

   modport source (output valid, r_w, r_x, r_y, r_z, overflow, input ready);
   modport sink   (input valid, r_w, r_x, r_y, r_z, overflow, output ready);
endinterface

@@ src/qau_sqrt.sv @@
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One root bit per stage, most significant first, with a running remainder
// so that no stage needs a multiplier.
// ----------------------------------------------------------------------------
module qau_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_vld,
   input  qau_pkg::side_type             in_side,
   input  logic [qau_pkg::NSQ_W-1:0]     in_nsq,
   output logic                          out_vld,
   output qau_pkg::side_type             out_side,
   output logic [qau_pkg::NSQ_W-1:0]     out_nsq
);

   localparam int NST  = qau_pkg::ROOT_W;
   localparam int RT_W = 2 * qau_pkg::ROOT_W + 1;

   logic                          vld_ff  [NST];
   qau_pkg::side_type             side_ff [NST];
   logic [qau_pkg::NSQ_W-1:0]     rem_ff  [NST];
   logic [qau_pkg::NSQ_W-1:0]     nsq_ff  [NST];
   logic [qau_pkg::ROOT_W-1:0]    root_ff [NST];

   for (genvar k = 0; k < NST; k++) begin : g_stage
      localparam int B = NST - 1 - k;

      logic                          vld_prev;
      qau_pkg::side_type             side_prev;
      logic [qau_pkg::NSQ_W-1:0]     rem_prev;
      logic [qau_pkg::NSQ_W-1:0]     nsq_prev;
      logic [qau_pkg::ROOT_W-1:0]    root_prev;
      logic [RT_W-1:0]               trial;
      logic                          take;
      logic [qau_pkg::NSQ_W-1:0]     rem_in;
      logic [qau_pkg::ROOT_W-1:0]    root_in;

      if (k == 0) begin : g_first
         assign vld_prev  = in_vld;
         assign side_prev = in_side;
         assign rem_prev  = in_nsq;
         assign nsq_prev  = in_nsq;
         assign root_prev = '0;
      end else begin : g_next
         assign vld_prev  = vld_ff[k-1];
         assign side_prev = side_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign nsq_prev  = nsq_ff[k-1];
         assign root_prev = root_ff[k-1];
      end

      // (root + 2^B)^2 - root^2 = root * 2^(B+1) + 2^(2B)
      assign trial   = (RT_W'(root_prev) << (B + 1)) + (RT_W'(1) << (2 * B));
      assign take    = RT_W'(rem_prev) >= trial;
      assign rem_in  = take ? qau_pkg::NSQ_W'(RT_W'(rem_prev) - trial) : rem_prev;
      assign root_in = take ? (root_prev | (qau_pkg::ROOT_W'(1) << B)) : root_prev;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_prev;
         end
         if (en) begin
            side_ff[k] <= side_prev;
            rem_ff[k]  <= rem_in;
            nsq_ff[k]  <= nsq_prev;
            root_ff[k] <= root_in;
         end
      end
   end

   always_comb begin
      out_side     = side_ff[NST-1];
      out_side.len = root_ff[NST-1];
   end

   assign out_vld = vld_ff[NST-1];
   assign out_nsq = nsq_ff[NST-1];

endmodule

@@ src/qau_div.sv @@
// ----------------------------------------------------------------------------
// Pipelined four-lane divider
// Restoring division, one quotient bit per stage, shared divisor. It divides
// by the squared norm for the inverse and by the length for normalize.
// ----------------------------------------------------------------------------
module qau_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_vld,
   input  qau_pkg::side_type             in_side,
   input  logic [qau_pkg::NSQ_W-1:0]     in_nsq,
   output logic                          out_vld,
   output qau_pkg::side_type             out_side,
   output logic [3:0][qau_pkg::QUO_W-1:0] out_quo
);

   localparam int NST = qau_pkg::QUO_W;

   logic                                  vld_ff  [NST];
   qau_pkg::side_type                     side_ff [NST];
   logic [qau_pkg::NSQ_W-1:0]             den_ff  [NST];
   logic [3:0][qau_pkg::DVD_W-1:0]        rem_ff  [NST];
   logic [3:0][qau_pkg::QUO_W-1:0]        quo_ff  [NST];

   logic [qau_pkg::NSQ_W-1:0]             den_first;
   logic [3:0][qau_pkg::DVD_W-1:0]        dvd_first;

   always_comb begin
      if (in_side.op == qau_pkg::OP_INV) begin
         den_first = in_nsq;
      end else begin
         den_first = qau_pkg::NSQ_W'(in_side.len);
      end
      for (int i = 0; i < 4; i++) begin
         if (in_side.op == qau_pkg::OP_INV) begin
            dvd_first[i] = qau_pkg::DVD_W'(in_side.mag[i]) << (2 * qau_pkg::FRAC_BITS);
         end else begin
            dvd_first[i] = qau_pkg::DVD_W'(in_side.mag[i]) << qau_pkg::FRAC_BITS;
         end
      end
   end

   for (genvar k = 0; k < NST; k++) begin : g_stage
      localparam int I = NST - 1 - k;

      logic                                  vld_prev;
      qau_pkg::side_type                     side_prev;
      logic [qau_pkg::NSQ_W-1:0]             den_prev;
      logic [3:0][qau_pkg::DVD_W-1:0]        rem_prev;
      logic [3:0][qau_pkg::QUO_W-1:0]        quo_prev;
      logic [qau_pkg::TRY_W-1:0]             trial;
      logic [3:0][qau_pkg::DVD_W-1:0]        rem_in;
      logic [3:0][qau_pkg::QUO_W-1:0]        quo_in;

      if (k == 0) begin : g_first
         assign vld_prev  = in_vld;
         assign side_prev = in_side;
         assign den_prev  = den_first;
         assign rem_prev  = dvd_first;
         assign quo_prev  = '0;
      end else begin : g_next
         assign vld_prev  = vld_ff[k-1];
         assign side_prev = side_ff[k-1];
         assign den_prev  = den_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign quo_prev  = quo_ff[k-1];
      end

      assign trial = qau_pkg::TRY_W'(den_prev) << I;

      always_comb begin
         for (int l = 0; l < 4; l++) begin
            if (qau_pkg::TRY_W'(rem_prev[l]) >= trial) begin
               rem_in[l] = qau_pkg::DVD_W'(qau_pkg::TRY_W'(rem_prev[l]) - trial);
               quo_in[l] = quo_prev[l] | (qau_pkg::QUO_W'(1) << I);
            end else begin
               rem_in[l] = rem_prev[l];
               quo_in[l] = quo_prev[l];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_prev;
         end
         if (en) begin
            side_ff[k] <= side_prev;
            den_ff[k]  <= den_prev;
            rem_ff[k]  <= rem_in;
            quo_ff[k]  <= quo_in;
         end
      end
   end

   assign out_vld  = vld_ff[NST-1];
   assign out_side = side_ff[NST-1];
   assign out_quo  = quo_ff[NST-1];

endmodule

@@ src/quaternion_arithmetic_unit.sv @@
// ----------------------------------------------------------------------------
// Quaternion arithmetic unit
// Signed Q15.16 quaternion ALU: add, subtract, Hamilton product, scale,
// conjugate, inverse, normalize and length, with saturation.
//
// Usage: a transaction on req_ch carries an operation code, operands a and b
// and a scalar; each one yields exactly one transaction on rsp_ch holding the
// result quaternion and an overflow flag. The b operand and the scalar are
// ignored by operations that do not use them.
// The datapath is a 70-stage pipeline: an input register, a multiply stage,
// a sum stage, 33 square-root stages, 33 divider stages and the output
// register. A result is offered 70 cycles after its transaction is taken,
// and a new transaction may be taken every cycle, so throughput is one item
// per clock. Every operation takes the full length, so results leave in order.
// When rsp_ch is stalled the whole pipeline holds and req_ch.ready drops;
// the output register keeps the waiting result. Bubbles are not squeezed out.
// A synchronous reset empties the pipeline; no result is pending afterwards.
// ----------------------------------------------------------------------------
module quaternion_arithmetic_unit (
   input  logic      clock,
   input  logic      reset,
   qau_req_if.sink   req_ch,
   qau_rsp_if.source rsp_ch
);

   localparam int COMP_W = qau_pkg::COMP_W;
   localparam int LIN_W  = COMP_W + 1;
   localparam logic signed [qau_pkg::HSUM_W-1:0] SAT_HI =
      (qau_pkg::HSUM_W'(1) <<< (COMP_W - 1)) - qau_pkg::HSUM_W'(1);
   localparam logic signed [qau_pkg::HSUM_W-1:0] SAT_LO =
      -(qau_pkg::HSUM_W'(1) <<< (COMP_W - 1));

   typedef struct packed {
      logic              ov;
      logic [COMP_W-1:0] val;
   } sat_type;

   function automatic sat_type sat(input logic signed [qau_pkg::HSUM_W-1:0] x);
      sat_type s;
      if (x > SAT_HI) begin
         s.ov  = 1'b1;
         s.val = SAT_HI[COMP_W-1:0];
      end else if (x < SAT_LO) begin
         s.ov  = 1'b1;
         s.val = SAT_LO[COMP_W-1:0];
      end else begin
         s.ov  = 1'b0;
         s.val = x[COMP_W-1:0];
      end
      return s;
   endfunction

   logic en;

   // Stage A: input register.
   logic                       vld_a_ff;
   qau_pkg::op_type            op_a_ff;
   logic signed [COMP_W-1:0]   a_a_ff [4];
   logic signed [COMP_W-1:0]   b_a_ff [4];
   logic signed [COMP_W-1:0]   s_a_ff;

   // Stage B: products and linear results.
   logic                                vld_b_ff;
   qau_pkg::op_type                     op_b_ff;
   logic signed [qau_pkg::PROD_W-1:0]   prod_ff [4][4];
   logic signed [qau_pkg::PROD_W-1:0]   prod_in [4][4];
   logic signed [COMP_W-1:0]            mul_rhs [4];
   logic signed [LIN_W-1:0]             lin_ff  [4];
   logic signed [LIN_W-1:0]             lin_in  [4];
   logic [3:0][COMP_W-1:0]              mag_b_ff;
   logic [3:0][COMP_W-1:0]              mag_b_in;
   logic [3:0]                          neg_b_ff;
   logic [3:0]                          neg_b_in;

   // Stage C: wide results before saturation and the squared norm.
   logic                                vld_c_ff;
   qau_pkg::op_type                     op_c_ff;
   logic signed [qau_pkg::HSUM_W-1:0]   wide_ff [4];
   logic signed [qau_pkg::HSUM_W-1:0]   wide_in [4];
   logic signed [qau_pkg::HSUM_W-1:0]   hsum    [4];
   logic [qau_pkg::NSQ_W-1:0]           nsq_ff;
   logic [qau_pkg::NSQ_W-1:0]           nsq_in;
   logic [3:0][COMP_W-1:0]              mag_c_ff;
   logic [3:0]                          neg_c_ff;

   qau_pkg::side_type                   side_c;

   logic                                sq_vld;
   qau_pkg::side_type                   sq_side;
   logic [qau_pkg::NSQ_W-1:0]           sq_nsq;

   logic                                dv_vld;
   qau_pkg::side_type                   dv_side;
   logic [3:0][qau_pkg::QUO_W-1:0]      dv_quo;

   // Output register.
   logic                       rsp_vld_ff;
   logic [3:0][COMP_W-1:0]     r_ff;
   logic [3:0][COMP_W-1:0]     r_in;
   logic                       ov_ff;
   logic                       ov_in;

   assign en           = !rsp_vld_ff || rsp_ch.ready;
   assign req_ch.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
      end else if (en) begin
         vld_a_ff <= req_ch.valid;
      end
      if (en) begin
         op_a_ff   <= qau_pkg::op_type'(req_ch.operation);
         a_a_ff[0] <= req_ch.a_w;
         a_a_ff[1] <= req_ch.a_x;
         a_a_ff[2] <= req_ch.a_y;
         a_a_ff[3] <= req_ch.a_z;
         b_a_ff[0] <= req_ch.b_w;
         b_a_ff[1] <= req_ch.b_x;
         b_a_ff[2] <= req_ch.b_y;
         b_a_ff[3] <= req_ch.b_z;
         s_a_ff    <= req_ch.scalar;
      end
   end

   // The sixteen multipliers form a*b for the product, a*scalar on the
   // diagonal for scale, and a*a otherwise so the diagonal gives the squares.
   always_comb begin
      for (int j = 0; j < 4; j++) begin
         if (op_a_ff == qau_pkg::OP_MUL) begin
            mul_rhs[j] = b_a_ff[j];
         end else if (op_a_ff == qau_pkg::OP_SCL) begin
            mul_rhs[j] = s_a_ff;
         end else begin
            mul_rhs[j] = a_a_ff[j];
         end
      end
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            prod_in[i][j] = qau_pkg::PROD_W'(a_a_ff[i]) * qau_pkg::PROD_W'(mul_rhs[j]);
         end
      end
      for (int i = 0; i < 4; i++) begin
         unique case (op_a_ff)
            qau_pkg::OP_ADD: lin_in[i] = LIN_W'(a_a_ff[i]) + LIN_W'(b_a_ff[i]);
            qau_pkg::OP_SUB: lin_in[i] = LIN_W'(a_a_ff[i]) - LIN_W'(b_a_ff[i]);
            qau_pkg::OP_CONJ: begin
               if (i == 0) begin
                  lin_in[i] = LIN_W'(a_a_ff[i]);
               end else begin
                  lin_in[i] = -LIN_W'(a_a_ff[i]);
               end
            end
            default: lin_in[i] = LIN_W'(a_a_ff[i]);
         endcase
         mag_b_in[i] = a_a_ff[i][COMP_W-1] ? COMP_W'(-a_a_ff[i]) : COMP_W'(a_a_ff[i]);
         // The inverse divides the conjugate, so the vector part flips sign.
         if (i != 0 && op_a_ff == qau_pkg::OP_INV) begin
            neg_b_in[i] = !a_a_ff[i][COMP_W-1] && (a_a_ff[i] != '0);
         end else begin
            neg_b_in[i] = a_a_ff[i][COMP_W-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_b_ff <= 1'b0;
      end else if (en) begin
         vld_b_ff <= vld_a_ff;
      end
      if (en) begin
         op_b_ff  <= op_a_ff;
         prod_ff  <= prod_in;
         lin_ff   <= lin_in;
         mag_b_ff <= mag_b_in;
         neg_b_ff <= neg_b_in;
      end
   end

   always_comb begin
      hsum[0] = qau_pkg::HSUM_W'(prod_ff[0][0]) - qau_pkg::HSUM_W'(prod_ff[1][1])
              - qau_pkg::HSUM_W'(prod_ff[2][2]) - qau_pkg::HSUM_W'(prod_ff[3][3]);
      hsum[1] = qau_pkg::HSUM_W'(prod_ff[0][1]) + qau_pkg::HSUM_W'(prod_ff[1][0])
              + qau_pkg::HSUM_W'(prod_ff[2][3]) - qau_pkg::HSUM_W'(prod_ff[3][2]);
      hsum[2] = qau_pkg::HSUM_W'(prod_ff[0][2]) - qau_pkg::HSUM_W'(prod_ff[1][3])
              + qau_pkg::HSUM_W'(prod_ff[2][0]) + qau_pkg::HSUM_W'(prod_ff[3][1]);
      hsum[3] = qau_pkg::HSUM_W'(prod_ff[0][3]) + qau_pkg::HSUM_W'(prod_ff[1][2])
              - qau_pkg::HSUM_W'(prod_ff[2][1]) + qau_pkg::HSUM_W'(prod_ff[3][0]);
      nsq_in = '0;
      for (int i = 0; i < 4; i++) begin
         nsq_in = nsq_in + qau_pkg::NSQ_W'($unsigned(prod_ff[i][i]));
      end
      for (int i = 0; i < 4; i++) begin
         unique case (op_b_ff)
            qau_pkg::OP_MUL: wide_in[i] = hsum[i] >>> qau_pkg::FRAC_BITS;
            qau_pkg::OP_SCL:
               wide_in[i] = qau_pkg::HSUM_W'(prod_ff[i][i]) >>> qau_pkg::FRAC_BITS;
            default: wide_in[i] = qau_pkg::HSUM_W'(lin_ff[i]);
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_c_ff <= 1'b0;
      end else if (en) begin
         vld_c_ff <= vld_b_ff;
      end
      if (en) begin
         op_c_ff  <= op_b_ff;
         wide_ff  <= wide_in;
         nsq_ff   <= nsq_in;
         mag_c_ff <= mag_b_ff;
         neg_c_ff <= neg_b_ff;
      end
   end

   always_comb begin
      sat_type s;
      side_c.op  = op_c_ff;
      side_c.nz  = nsq_ff != '0;
      side_c.ov  = 1'b0;
      side_c.mag = mag_c_ff;
      side_c.neg = neg_c_ff;
      side_c.len = '0;
      for (int i = 0; i < 4; i++) begin
         s             = sat(wide_ff[i]);
         side_c.res[i] = s.val;
         side_c.ov     = side_c.ov | s.ov;
      end
   end

   qau_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (vld_c_ff),
      .in_side  (side_c),
      .in_nsq   (nsq_ff),
      .out_vld  (sq_vld),
      .out_side (sq_side),
      .out_nsq  (sq_nsq)
   );

   qau_div u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (sq_vld),
      .in_side  (sq_side),
      .in_nsq   (sq_nsq),
      .out_vld  (dv_vld),
      .out_side (dv_side),
      .out_quo  (dv_quo)
   );

   always_comb begin
      sat_type                             s;
      logic signed [qau_pkg::HSUM_W-1:0]   q;
      r_in  = dv_side.res;
      ov_in = dv_side.ov;
      unique case (dv_side.op)
         qau_pkg::OP_INV, qau_pkg::OP_NORM: begin
            ov_in = 1'b0;
            for (int i = 0; i < 4; i++) begin
               q = qau_pkg::HSUM_W'(dv_quo[i]);
               if (dv_side.neg[i]) begin
                  q = -q;
               end
               s = sat(q);
               if (dv_side.nz) begin
                  r_in[i] = s.val;
                  ov_in   = ov_in | s.ov;
               end else begin
                  r_in[i] = '0;
               end
            end
         end
         qau_pkg::OP_LEN: begin
            s     = sat(qau_pkg::HSUM_W'(dv_side.len));
            r_in  = '0;
            r_in[0] = s.val;
            ov_in = s.ov;
         end
         default: begin
            r_in  = dv_side.res;
            ov_in = dv_side.ov;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (en) begin
         rsp_vld_ff <= dv_vld;
      end
      if (en) begin
         r_ff  <= r_in;
         ov_ff <= ov_in;
      end
   end

   assign rsp_ch.valid    = rsp_vld_ff;
   assign rsp_ch.r_w      = r_ff[0];
   assign rsp_ch.r_x      = r_ff[1];
   assign rsp_ch.r_y      = r_ff[2];
   assign rsp_ch.r_z      = r_ff[3];
   assign rsp_ch.overflow = ov_ff;

endmodule
